// File: sv/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared constants, result codes and controller/datapath interface types
// for the interval reservation table.
// ----------------------------------------------------------------------------
package irt_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam int IN_TIME_W = 32;
  localparam int STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] ST_BOOKED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADRANGE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;    // latch a new request, restart the scan
    logic scan;    // walk the stored entries
    logic finish;  // resolve the result and commit when the output is free
  } irt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } irt_stat_t;

endpackage

// File: sv/irt_ram.sv
// ----------------------------------------------------------------------------
// irt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module irt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/irt_ctrl.sv
// ----------------------------------------------------------------------------
// irt_ctrl
// Request sequencer: accept, scan the table, then commit the result.
// ----------------------------------------------------------------------------
module irt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output irt_pkg::irt_cmd_t cmd,
  input  irt_pkg::irt_stat_t stat
);
  import irt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/irt_dpath.sv
// ----------------------------------------------------------------------------
// irt_dpath
// Request registers, interval store, scan counter, overlap compare and
// output register. Entries are never released, so the valid entries are
// always slots 0 .. used-1 and the fill count stands in for valid bits.
// ----------------------------------------------------------------------------
module irt_dpath #(
  parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irt_pkg::irt_cmd_t             cmd,
  output irt_pkg::irt_stat_t            stat,
  input  logic [irt_pkg::IN_TIME_W-1:0] in_start_time,
  input  logic [irt_pkg::IN_TIME_W-1:0] in_end_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [irt_pkg::STATUS_W-1:0]  out_status
);
  import irt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // inputs widened to 64 then cut to the time width (masks or zero-extends)
  logic [63:0]          start_ext;
  logic [63:0]          end_ext;
  logic [TIME_BITS-1:0] start_t;
  logic [TIME_BITS-1:0] end_t;

  logic [TIME_BITS-1:0] req_start_r, req_start_nxt;
  logic [TIME_BITS-1:0] req_end_r, req_end_nxt;
  logic                 bad_r, bad_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        issue_r, issue_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 hit_r, hit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic                 issue_rd;
  logic                 overlap;
  logic                 commit;
  logic                 we;
  logic [STATUS_W-1:0]  status_c;
  logic [2*TIME_BITS-1:0] rdata;
  logic [TIME_BITS-1:0] rd_start;
  logic [TIME_BITS-1:0] rd_end;

  assign start_ext = {32'b0, in_start_time};
  assign end_ext   = {32'b0, in_end_time};
  assign start_t   = start_ext[TIME_BITS-1:0];
  assign end_t     = end_ext[TIME_BITS-1:0];

  assign rd_start = rdata[TIME_BITS-1:0];
  assign rd_end   = rdata[2*TIME_BITS-1:TIME_BITS];

  assign overlap  = (req_start_r < rd_end) && (req_end_r > rd_start);
  assign issue_rd = cmd.scan && !bad_r && !hit_r && (issue_r < count_r);

  assign stat.scan_done = bad_r || hit_r || ((issue_r >= count_r) && !rd_pend_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign commit = cmd.finish && stat.out_free;

  always_comb begin
    priority if (bad_r) begin
      status_c = ST_BADRANGE;
    end else if (hit_r) begin
      status_c = ST_OVERLAP;
    end else if (count_r == CW'(CAPACITY)) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_BOOKED;
    end
  end

  assign we = commit && (status_c == ST_BOOKED);

  irt_ram #(
    .WIDTH (2 * TIME_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata ({req_end_r, req_start_r}),
    .raddr (issue_r[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    req_start_nxt  = req_start_r;
    req_end_nxt    = req_end_r;
    bad_nxt        = bad_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    rd_pend_nxt    = issue_rd;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_acc_nxt    = out_acc_r;
    out_status_nxt = out_status_r;

    if (cmd.load) begin
      req_start_nxt = start_t;
      req_end_nxt   = end_t;
      bad_nxt       = (start_t >= end_t);
      issue_nxt     = '0;
      rd_pend_nxt   = 1'b0;
      hit_nxt       = 1'b0;
    end

    if (issue_rd) begin
      issue_nxt = issue_r + CW'(1);
    end

    // read data lands in the cycle after its address was issued
    if (cmd.scan && rd_pend_r && overlap) begin
      hit_nxt = 1'b1;
    end

    if (commit) begin
      out_valid_nxt  = 1'b1;
      out_acc_nxt    = (status_c == ST_BOOKED);
      out_status_nxt = status_c;
    end

    if (we) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_start_r  <= req_start_nxt;
    req_end_r    <= req_end_nxt;
    bad_r        <= bad_nxt;
    out_acc_r    <= out_acc_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_status   = out_status_r;

endmodule

// File: sv/interval_reservation_table.sv
// ----------------------------------------------------------------------------
// interval_reservation_table
// Books disjoint half-open intervals [start,end); rejects inverted or empty requests,
// overlaps and requests that arrive with the table full.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------
//   in_     | input     | in_valid/in_stall| in_start_time, in_end_time
//   out_    | output    | out_valid/out_stall | out_accepted, out_status
//
// One request at a time. The scan reads one stored interval per cycle
// from the single read port of the interval store. An overlap ends the
// scan early. An inverted request, or any request on an empty table,
// resolves without reading the store. The next transfer can follow in
// the cycle after the result is loaded.
// Reset clears the fill count; store contents need no clearing.
// in_stall stays high from the transfer until the result is loaded into the
// output register; a stalled output holds the block in its final step.
// ----------------------------------------------------------------------------
module interval_reservation_table #(
  parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [irt_pkg::IN_TIME_W-1:0] in_start_time,
  input  logic [irt_pkg::IN_TIME_W-1:0] in_end_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [irt_pkg::STATUS_W-1:0]  out_status
);
  import irt_pkg::*;

  irt_cmd_t  cmd;
  irt_stat_t stat;

  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  irt_dpath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_start_time (in_start_time),
    .in_end_time   (in_end_time),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_accepted  (out_accepted),
    .out_status    (out_status)
  );

endmodule

// File: sv/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker
// Port-level checks for the interval reservation table, bound to the top.
// ----------------------------------------------------------------------------
module irt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [irt_pkg::IN_TIME_W-1:0] in_start_time,
  input logic [irt_pkg::IN_TIME_W-1:0] in_end_time,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_accepted,
  input logic [irt_pkg::STATUS_W-1:0]  out_status
);
  import irt_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted) && $stable(out_status))
    else $error("stalled result changed");

  // accepted flag agrees with the status code
  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_status == ST_BOOKED)))
    else $error("accepted flag disagrees with status");

  // one request at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("bad state after reset");

endmodule

bind interval_reservation_table irt_checker u_irt_checker (.*);
